>>> hw/rtl/frd_pkg.sv
`timescale 1ns / 1ps

package frd_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int CNT_WIDTH  = $clog2(DATA_WIDTH);

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] numerator_in;
      logic signed [DATA_WIDTH-1:0] denominator_in;
   } frd_req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] numerator_out;
      logic signed [DATA_WIDTH-1:0] denominator_out;
      logic                         zero_fraction_error;
   } frd_rsp_type;

   typedef struct packed {
      logic                  start;
      logic [DATA_WIDTH-1:0] dividend;
      logic [DATA_WIDTH-1:0] divisor;
   } frd_div_req_type;

   typedef struct packed {
      logic                  done;
      logic [DATA_WIDTH-1:0] quotient;
      logic [DATA_WIDTH-1:0] remainder;
   } frd_div_rsp_type;

endpackage

>>> hw/rtl/frd_divider.sv
`timescale 1ns / 1ps

module frd_divider
   import frd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  frd_div_req_type div_req,
   output frd_div_rsp_type div_rsp
);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_WIDTH-1:0]  cnt_ff, cnt_in;
   logic [DATA_WIDTH-1:0] rem_ff, rem_in;
   logic [DATA_WIDTH-1:0] quo_ff, quo_in;
   logic [DATA_WIDTH-1:0] dvs_ff, dvs_in;

   logic [DATA_WIDTH:0]   shifted;
   logic [DATA_WIDTH:0]   diff;

   assign shifted = {rem_ff, quo_ff[DATA_WIDTH-1]};
   assign diff    = shifted - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_WIDTH'(DATA_WIDTH - 1);
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         if (!diff[DATA_WIDTH]) begin
            rem_in = diff[DATA_WIDTH-1:0];
            quo_in = {quo_ff[DATA_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = shifted[DATA_WIDTH-1:0];
            quo_in = {quo_ff[DATA_WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

`ifndef SYNTH
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !busy_ff)
      else $error("divider started while busy");

   a_last_step_done: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !div_req.start && cnt_ff == '0 |=> done_ff && !busy_ff)
      else $error("divider missed its done pulse");

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> rem_ff < dvs_ff)
      else $error("divider remainder not below divisor");
`endif

endmodule

>>> hw/rtl/fraction_reducer.sv
// Reduces by Euclid's algorithm on the magnitudes, one divide per step, then divides numerator
// and denominator by the GCD, all on one restoring divider; a zero pair is flagged without a divide.
// A new word is not taken until the last one reaches the output register; req_ready is high only while idle.
// A finished word sits in the output register, so the next request is taken while it waits.
// Reset: synchronous, active high; clears the sequencer, the divider and rsp_valid.
`timescale 1ns / 1ps

module fraction_reducer
   import frd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  frd_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output frd_rsp_type rsp_data
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_CHECK = 6'b000010,
      ST_GCD   = 6'b000100,
      ST_DIVN  = 6'b001000,
      ST_DIVD  = 6'b010000,
      ST_OUT   = 6'b100000
   } frd_state_type;

   frd_state_type state_ff, state_in;

   logic                         div_start_ff, div_start_in;
   logic                         a_neg_ff, a_neg_in, b_neg_ff, b_neg_in;
   logic [DATA_WIDTH-1:0]        a_mag_ff, a_mag_in, b_mag_ff, b_mag_in;
   logic                         num_neg_ff, num_neg_in, den_neg_ff, den_neg_in;
   logic [DATA_WIDTH-1:0]        num_mag_ff, num_mag_in, den_mag_ff, den_mag_in;
   logic signed [DATA_WIDTH-1:0] qn_ff, qn_in, qd_ff, qd_in;
   logic                         err_ff, err_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   frd_rsp_type                  rsp_data_ff, rsp_data_in;

   logic [DATA_WIDTH-1:0] num_raw, den_raw;
   logic                  out_free;
   frd_div_req_type       div_req;
   frd_div_rsp_type       div_rsp;

   frd_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign num_raw   = req_data.numerator_in;
   assign den_raw   = req_data.denominator_in;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      div_req.start = div_start_ff;
      case (state_ff)
         ST_GCD: begin
            div_req.dividend = a_mag_ff;
            div_req.divisor  = b_mag_ff;
         end
         ST_DIVN: begin
            div_req.dividend = num_mag_ff;
            div_req.divisor  = a_mag_ff;
         end
         default: begin
            div_req.dividend = den_mag_ff;
            div_req.divisor  = a_mag_ff;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      div_start_in = 1'b0;
      a_neg_in     = a_neg_ff;
      a_mag_in     = a_mag_ff;
      b_neg_in     = b_neg_ff;
      b_mag_in     = b_mag_ff;
      num_neg_in   = num_neg_ff;
      num_mag_in   = num_mag_ff;
      den_neg_in   = den_neg_ff;
      den_mag_in   = den_mag_ff;
      qn_in        = qn_ff;
      qd_in        = qd_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               num_neg_in = num_raw[DATA_WIDTH-1];
               num_mag_in = num_raw[DATA_WIDTH-1] ? (~num_raw + 1'b1) : num_raw;
               den_neg_in = den_raw[DATA_WIDTH-1];
               den_mag_in = den_raw[DATA_WIDTH-1] ? (~den_raw + 1'b1) : den_raw;
               a_neg_in   = num_neg_in;
               a_mag_in   = num_mag_in;
               b_neg_in   = den_neg_in;
               b_mag_in   = den_mag_in;
               state_in   = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (b_mag_ff != '0) begin
               div_start_in = 1'b1;
               state_in     = ST_GCD;
            end else if (a_mag_ff == '0) begin
               qn_in    = '0;
               qd_in    = '0;
               err_in   = 1'b1;
               state_in = ST_OUT;
            end else begin
               err_in       = 1'b0;
               div_start_in = 1'b1;
               state_in     = ST_DIVN;
            end
         end
         ST_GCD: begin
            if (div_rsp.done) begin
               a_neg_in = b_neg_ff;
               a_mag_in = b_mag_ff;
               b_neg_in = a_neg_ff && (div_rsp.remainder != '0);
               b_mag_in = div_rsp.remainder;
               state_in = ST_CHECK;
            end
         end
         ST_DIVN: begin
            if (div_rsp.done) begin
               qn_in = (num_neg_ff ^ a_neg_ff) ? $signed(-div_rsp.quotient)
                                               : $signed(div_rsp.quotient);
               div_start_in = 1'b1;
               state_in     = ST_DIVD;
            end
         end
         ST_DIVD: begin
            if (div_rsp.done) begin
               qd_in = (den_neg_ff ^ a_neg_ff) ? $signed(-div_rsp.quotient)
                                               : $signed(div_rsp.quotient);
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in                    = 1'b1;
               rsp_data_in.numerator_out       = qn_ff;
               rsp_data_in.denominator_out     = qd_ff;
               rsp_data_in.zero_fraction_error = err_ff;
               state_in                        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         div_start_ff <= div_start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      a_neg_ff    <= a_neg_in;
      a_mag_ff    <= a_mag_in;
      b_neg_ff    <= b_neg_in;
      b_mag_ff    <= b_mag_in;
      num_neg_ff  <= num_neg_in;
      num_mag_ff  <= num_mag_in;
      den_neg_ff  <= den_neg_in;
      den_mag_ff  <= den_mag_in;
      qn_ff       <= qn_in;
      qd_ff       <= qd_in;
      err_ff      <= err_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   a_accept_to_check: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == ST_CHECK)
      else $error("accepted word did not enter the check step");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.zero_fraction_error |->
         rsp_data.numerator_out == '0 && rsp_data.denominator_out == '0)
      else $error("error word carries nonzero fields");

   a_done_in_div_state: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == ST_GCD || state_ff == ST_DIVN || state_ff == ST_DIVD)
      else $error("divider done outside a divide step");

   a_zero_pair_error: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CHECK && b_mag_ff == '0 && a_mag_ff == '0 |=>
         state_ff == ST_OUT && err_ff)
      else $error("zero pair not flagged");
`endif

endmodule
